// File: src/ysrc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the YCbCr-sum to RGB converter.
// No dependencies.
package ysrc_pkg;

    localparam int SUM_BITS_DEF = 16;
    localparam int PIX_W        = 8;
    localparam int SCALE_W      = 33;
    localparam int COEF_W       = 32;
    localparam int CFG_DATA_W   = 33;
    localparam int CFG_ADDR_W   = 3;
    localparam int FRAC_W       = 32;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_LUMA_SCALE    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CB_BLUE_COEF  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_CB_GREEN_COEF = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_CR_GREEN_COEF = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_CR_RED_COEF   = 3'd4;

    localparam logic [SCALE_W-1:0] LUMA_SCALE_RST    = 33'h1_0000_0000;
    localparam logic [COEF_W-1:0]  CB_BLUE_COEF_RST  = 32'd3698982649;
    localparam logic [COEF_W-1:0]  CB_GREEN_COEF_RST = 32'd1478070045;
    localparam logic [COEF_W-1:0]  CR_GREEN_COEF_RST = 32'd3067208968;
    localparam logic [COEF_W-1:0]  CR_RED_COEF_RST   = 32'd3010771050;

    // channel offsets in 32.32 with the rounding half (2^31) folded in
    localparam logic signed [63:0] HALF_LSB   = 64'sd2147483648;
    localparam logic signed [63:0] BLUE_BIAS  =
        HALF_LSB - ((64'sd220 <<< 32) + 64'sd687194767);
    localparam logic signed [63:0] GREEN_BIAS =
        HALF_LSB + ((64'sd135 <<< 32) + 64'sd1974997761);
    localparam logic signed [63:0] RED_BIAS   =
        HALF_LSB - ((64'sd179 <<< 32) + 64'sd1958505087);

    typedef struct packed {
        logic [SCALE_W-1:0] luma_scale;
        logic [COEF_W-1:0]  cb_blue_coef;
        logic [COEF_W-1:0]  cb_green_coef;
        logic [COEF_W-1:0]  cr_green_coef;
        logic [COEF_W-1:0]  cr_red_coef;
    } t_cfg;

endpackage

// File: src/ysrc_regs.sv
`timescale 1ns / 1ps
// Configuration register file: scale and chroma coefficients.
// Depends on ysrc_pkg.
module ysrc_regs
    import ysrc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [CFG_ADDR_W-1:0] i_addr,
    input  logic [CFG_DATA_W-1:0] i_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.luma_scale    <= LUMA_SCALE_RST;
            r_cfg.cb_blue_coef  <= CB_BLUE_COEF_RST;
            r_cfg.cb_green_coef <= CB_GREEN_COEF_RST;
            r_cfg.cr_green_coef <= CR_GREEN_COEF_RST;
            r_cfg.cr_red_coef   <= CR_RED_COEF_RST;
        end else if (i_we) begin
            case (i_addr)
                CFG_LUMA_SCALE:    r_cfg.luma_scale    <= i_wdata[SCALE_W-1:0];
                CFG_CB_BLUE_COEF:  r_cfg.cb_blue_coef  <= i_wdata[COEF_W-1:0];
                CFG_CB_GREEN_COEF: r_cfg.cb_green_coef <= i_wdata[COEF_W-1:0];
                CFG_CR_GREEN_COEF: r_cfg.cr_green_coef <= i_wdata[COEF_W-1:0];
                CFG_CR_RED_COEF:   r_cfg.cr_red_coef   <= i_wdata[COEF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: src/ysrc_clamp.sv
`timescale 1ns / 1ps
// Takes a signed (VW-32).32 channel value (rounding half already added),
// drops the fraction and saturates to 0..255. Depends on ysrc_pkg.
module ysrc_clamp
    import ysrc_pkg::*;
#(
    parameter int VW = SUM_BITS_DEF + 36
) (
    input  logic signed [VW-1:0] i_val,
    output logic [PIX_W-1:0]     o_pix
);

    logic w_neg;
    logic w_over;

    assign w_neg  = i_val[VW-1];
    assign w_over = |i_val[VW-2:FRAC_W+PIX_W];

    always_comb begin
        if (w_neg) begin
            o_pix = '0;
        end else if (w_over) begin
            o_pix = '1;
        end else begin
            o_pix = i_val[FRAC_W+PIX_W-1:FRAC_W];
        end
    end

endmodule

// File: src/ycbcr_sum_to_rgb_convert_core.sv
`timescale 1ns / 1ps
// Converts accumulated Y/Cb/Cr sample sums of one pixel to 8-bit B, G, R.
// Usage:
//   Input stream s_axis_*: tdata carries luma_sum, blue_diff_sum and
//   red_diff_sum (SUM_BITS each, lowest first); tlast marks the row end.
//   Output stream m_axis_*: tdata carries blue, green, red (8 bits each,
//   blue lowest); tlast is the row-end mark carried through.
//   A request is taken when tvalid and tready are both high.
//   Config: i_cfg_we writes i_cfg_wdata into register i_cfg_addr
//   (0 luma scale, 1 Cb->B, 2 Cb->G, 3 Cr->G, 4 Cr->R); other indexes are
//   dropped. Write only while the pipeline is empty.
// Timing:
//   Four register stages (multiply, partial sums, channel sums, clamp to
//   output register); one pixel per clock while the receiver does not stall.
//   The multiply stage (five 32 x SUM_BITS products) sets the clock.
//   When the receiver stalls, each stage holds; empty stages still load,
//   so up to four pixels are absorbed before s_axis_tready drops.
// Reset: clears all valid bits and loads the default coefficients.
// Depends on ysrc_pkg, ysrc_regs, ysrc_clamp.
module ycbcr_sum_to_rgb_convert_core
    import ysrc_pkg::*;
#(
    parameter int SUM_BITS = SUM_BITS_DEF,
    localparam int IN_W    = ((3 * SUM_BITS + 7) / 8) * 8,
    localparam int OUT_W   = 3 * PIX_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // luma_sum, blue_diff_sum, red_diff_sum (low to high), zero padded
    input  logic [IN_W-1:0]       s_axis_tdata,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // blue_out, green_out, red_out (low to high)
    output logic [OUT_W-1:0]      m_axis_tdata,
    output logic                  m_axis_tlast,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int P_W  = COEF_W + SUM_BITS;   // product width
    localparam int Y_W  = P_W + 1;             // scaled luma width
    localparam int VW   = SUM_BITS + 36;       // signed channel width
    localparam logic signed [VW-1:0] K_B = VW'(BLUE_BIAS);
    localparam logic signed [VW-1:0] K_G = VW'(GREEN_BIAS);
    localparam logic signed [VW-1:0] K_R = VW'(RED_BIAS);

    t_cfg w_cfg;

    ysrc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_addr  (i_cfg_addr),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (w_cfg)
    );

    // stage enables, back to front
    logic w_en1, w_en2, w_en3, w_en4;
    logic r_v1, r_v2, r_v3, r_v4;
    logic r_last1, r_last2, r_last3, r_last4;

    assign w_en4 = !r_v4 || m_axis_tready;
    assign w_en3 = !r_v3 || w_en4;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;
    assign s_axis_tready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= s_axis_tvalid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
        end
    end

    // ---------------- stage 1: products ----------------
    logic [SUM_BITS-1:0] w_y, w_cb, w_cr;
    assign w_y  = s_axis_tdata[SUM_BITS-1:0];
    assign w_cb = s_axis_tdata[2*SUM_BITS-1:SUM_BITS];
    assign w_cr = s_axis_tdata[3*SUM_BITS-1:2*SUM_BITS];

    logic [P_W-1:0]      r_p_lum, r_p_cbb, r_p_cbg, r_p_crg, r_p_crr;
    logic [SUM_BITS-1:0] r_y_hi;

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_p_lum <= P_W'(w_cfg.luma_scale[COEF_W-1:0]) * P_W'(w_y);
            r_p_cbb <= P_W'(w_cfg.cb_blue_coef) * P_W'(w_cb);
            r_p_cbg <= P_W'(w_cfg.cb_green_coef) * P_W'(w_cb);
            r_p_crg <= P_W'(w_cfg.cr_green_coef) * P_W'(w_cr);
            r_p_crr <= P_W'(w_cfg.cr_red_coef) * P_W'(w_cr);
            // scale bit 32 adds y in the integer part
            r_y_hi  <= w_cfg.luma_scale[SCALE_W-1] ? w_y : '0;
            r_last1 <= s_axis_tlast;
        end
    end

    // ---------------- stage 2: luma and offset terms ----------------
    logic [Y_W-1:0]        n_y;
    logic signed [VW-1:0]  n_db, n_dg, n_dr;
    logic [Y_W-1:0]        r_y;
    logic signed [VW-1:0]  r_db, r_dg, r_dr;

    always_comb begin
        n_y  = Y_W'(r_p_lum) + Y_W'({r_y_hi, {FRAC_W{1'b0}}});
        n_db = $signed(VW'({r_p_cbb, 1'b0})) + K_B;
        n_dg = K_G - $signed(VW'(r_p_cbg)) - $signed(VW'(r_p_crg));
        n_dr = $signed(VW'({r_p_crr, 1'b0})) + K_R;
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_y     <= n_y;
            r_db    <= n_db;
            r_dg    <= n_dg;
            r_dr    <= n_dr;
            r_last2 <= r_last1;
        end
    end

    // ---------------- stage 3: channel sums ----------------
    logic signed [VW-1:0] w_y_s;
    logic signed [VW-1:0] r_b, r_g, r_r;

    assign w_y_s = $signed(VW'(r_y));

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_b     <= w_y_s + r_db;
            r_g     <= w_y_s + r_dg;
            r_r     <= w_y_s + r_dr;
            r_last3 <= r_last2;
        end
    end

    // ---------------- stage 4: round, clamp, output ----------------
    logic [PIX_W-1:0] w_pb, w_pg, w_pr;
    logic [OUT_W-1:0] r_pix;

    ysrc_clamp #(.VW(VW)) u_clamp_b (.i_val(r_b), .o_pix(w_pb));
    ysrc_clamp #(.VW(VW)) u_clamp_g (.i_val(r_g), .o_pix(w_pg));
    ysrc_clamp #(.VW(VW)) u_clamp_r (.i_val(r_r), .o_pix(w_pr));

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_pix   <= {w_pr, w_pg, w_pb};
            r_last4 <= r_last3;
        end
    end

    assign m_axis_tvalid = r_v4;
    assign m_axis_tdata  = r_pix;
    assign m_axis_tlast  = r_last4;

`ifndef SYNTHESIS
    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_v1)
        else $error("accepted request did not reach stage 1");

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && r_v4 && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while pipeline full and stalled");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !w_en2) |=> (r_v1 && $stable(r_p_lum) && $stable(r_p_crr)))
        else $error("stalled stage 1 lost its products");

    a_s3_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !w_en4) |=> (r_v3 && $stable(r_g) && $stable(r_last3)))
        else $error("stalled stage 3 changed");
`endif

endmodule
